### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, skipped while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, skipped while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/tpvt_pkg.sv
package tpvt_pkg;

    localparam int RAW_W  = 12;
    localparam int LEN_W  = 16;
    localparam int SPAN_W = 9;
    localparam int PER_W  = 16;
    localparam int POS_W  = 17;
    localparam int VEL_W  = 32;

    // register indexes
    localparam logic [2:0] REG_X_MAX  = 3'd0;
    localparam logic [2:0] REG_X_MIN  = 3'd1;
    localparam logic [2:0] REG_X_LEN  = 3'd2;
    localparam logic [2:0] REG_Y_MAX  = 3'd3;
    localparam logic [2:0] REG_Y_MIN  = 3'd4;
    localparam logic [2:0] REG_Y_LEN  = 3'd5;
    localparam logic [2:0] REG_N      = 3'd6;

    localparam logic signed [21:0] US_PER_S = 22'sd1000000;

    // divider widths
    localparam int DIV_W = 48;

    typedef struct packed {
        logic [RAW_W-1:0] raw_max;
        logic [RAW_W-1:0] raw_min;
        logic [LEN_W-1:0] len;
    } axis_cfg_t;

    // lane start / touch flag
    typedef struct packed {
        logic start;
        logic touched;
    } lane_ctl_t;

    typedef struct packed {
        logic pos_done;
        logic vel_done;
    } lane_sts_t;

endpackage

### hw/rtl/tpvt_if.sv
interface tpvt_in_if;
    logic        valid;
    logic        ready;
    logic        is_touched;
    logic [11:0] raw_x;
    logic [11:0] raw_y;
    logic [15:0] period_us;
    modport source (output valid, is_touched, raw_x, raw_y, period_us, input ready);
    modport sink (input valid, is_touched, raw_x, raw_y, period_us, output ready);
endinterface

interface tpvt_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
    modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface tpvt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/tpvt_div.sv
// Restoring serial divider: signed operands, quotient truncated toward zero,
// one quotient bit per cycle.
module tpvt_div
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [tpvt_pkg::DIV_W-1:0]  num,
    input  logic signed [tpvt_pkg::DIV_W-1:0]  den,
    output logic                               done,
    output logic signed [tpvt_pkg::DIV_W-1:0]  quo
);
    import tpvt_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] q_reg, q_next;
    logic [DIV_W-1:0] r_reg, r_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W-1:0] r_shift;

    // one restoring step per cycle
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        r_shift   = {r_reg[DIV_W-2:0], q_reg[DIV_W-1]};
        trial     = {1'b0, r_shift} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = num[DIV_W-1] ? DIV_W'(-num) : num;
            d_next    = den[DIV_W-1] ? DIV_W'(-den) : den;
            r_next    = '0;
            neg_next  = num[DIV_W-1] ^ den[DIV_W-1];
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W])
            begin
                r_next = trial[DIV_W-1:0];
                q_next = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r_next = r_shift;
                q_next = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? DIV_W'(-q_reg) : q_reg;

    `include "assert_macros.svh"
    `ASSERT_NEXT(a_done_ends_busy, clk, rst_n, done_next, !busy_reg)
    `ASSERT_IMPL(a_no_start_busy, clk, rst_n, start, !busy_reg)
    `ASSERT_IMPL(a_done_one_cycle, clk, rst_n, done_reg, !$past(done_reg))
endmodule

### hw/rtl/tpvt_lane.sv
// One axis lane: position by calibration divide (touched, nonzero span), then
// velocity divide and averaging divide, all through one shared serial divider.
module tpvt_lane
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  tpvt_pkg::lane_ctl_t                ctl,
    input  tpvt_pkg::axis_cfg_t                cfg,
    input  logic [tpvt_pkg::RAW_W-1:0]         raw,
    input  logic [tpvt_pkg::PER_W-1:0]         period,
    input  logic [tpvt_pkg::SPAN_W-1:0]        span,
    output tpvt_pkg::lane_sts_t                sts,
    output logic signed [tpvt_pkg::POS_W-1:0]  pos,
    output logic signed [tpvt_pkg::VEL_W-1:0]  vel
);
    import tpvt_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_POS  = 3'd2;
    localparam logic [2:0] ST_VMUL = 3'd3;
    localparam logic [2:0] ST_VEL  = 3'd4;
    localparam logic [2:0] ST_AVG  = 3'd5;

    logic [2:0]                st_reg, st_next;
    logic signed [POS_W-1:0]   last_reg, last_next;
    logic signed [VEL_W-1:0]   avg_reg, avg_next;
    logic signed [DIV_W-1:0]   num_reg, num_next;
    logic signed [DIV_W-1:0]   den_reg, den_next;
    logic                      dstart_reg, dstart_next;
    logic signed [POS_W-1:0]   pos_reg, pos_next;
    logic                      pdone, vdone;
    logic                      vdone_reg;
    logic                      ddone;
    logic signed [DIV_W-1:0]   dquo;
    logic signed [RAW_W+2:0]   cnum;
    logic signed [RAW_W+2:0]   cden;
    logic signed [POS_W:0]     dpos;
    logic signed [DIV_W-1:0]   vdiff;
    logic signed [DIV_W-1:0]   anext;

    tpvt_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart_reg),
        .num   (num_reg),
        .den   (den_reg),
        .done  (ddone),
        .quo   (dquo)
    );

    assign cnum = (RAW_W+3)'({2'b0, raw, 1'b0}) - (RAW_W+3)'({3'b0, cfg.raw_max})
                - (RAW_W+3)'({3'b0, cfg.raw_min});
    assign cden = (RAW_W+3)'({2'b0, cfg.raw_max, 1'b0})
                - (RAW_W+3)'({2'b0, cfg.raw_min, 1'b0});
    assign dpos  = (POS_W+1)'(pos_reg) - (POS_W+1)'(last_reg);
    // velocity sample can reach far past 32 bits before averaging
    assign vdiff = dquo - DIV_W'(avg_reg);

    // sequencer: position, velocity, average
    always_comb
    begin
        st_next     = st_reg;
        last_next   = last_reg;
        avg_next    = avg_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        pos_next    = pos_reg;
        dstart_next = 1'b0;
        pdone       = 1'b0;
        vdone       = 1'b0;
        anext       = '0;
        case (st_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    if (ctl.touched && cden != '0)
                    begin
                        num_next = DIV_W'(cnum);
                        den_next = DIV_W'(cden);
                        st_next  = ST_MUL;
                    end
                    else
                    begin
                        pos_next = ctl.touched ? '0 : last_reg;
                        st_next  = ST_VMUL;
                    end
                end
            end
            ST_MUL:
            begin
                // 15 x 17 signed product into the dividend
                num_next    = DIV_W'($signed(num_reg[RAW_W+2:0]) * $signed({1'b0, cfg.len}));
                dstart_next = 1'b1;
                st_next     = ST_POS;
            end
            ST_POS:
            begin
                if (ddone)
                begin
                    if (dquo > DIV_W'(65535))
                        pos_next = 17'sd65535;
                    else if (dquo < -DIV_W'(65536))
                        pos_next = -17'sd65536;
                    else
                        pos_next = POS_W'(dquo);
                    st_next = ST_VMUL;
                end
            end
            ST_VMUL:
            begin
                num_next    = DIV_W'(dpos * US_PER_S);
                den_next    = DIV_W'({1'b0, (period == '0) ? PER_W'(1) : period});
                dstart_next = 1'b1;
                st_next     = ST_VEL;
            end
            ST_VEL:
            begin
                if (ddone)
                begin
                    num_next    = vdiff;
                    den_next    = DIV_W'({1'b0, (span == '0) ? SPAN_W'(1) : span});
                    dstart_next = 1'b1;
                    pdone       = 1'b1;
                    st_next     = ST_AVG;
                end
            end
            ST_AVG:
            begin
                if (ddone)
                begin
                    anext = DIV_W'(avg_reg) + dquo;
                    if (anext > DIV_W'(32'sh7fffffff))
                        avg_next = 32'sh7fffffff;
                    else if (anext < -DIV_W'(34'sh80000000))
                        avg_next = 32'sh80000000;
                    else
                        avg_next = VEL_W'(anext);
                    last_next = pos_reg;
                    vdone     = 1'b1;
                    st_next   = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            last_reg   <= '0;
            avg_reg    <= '0;
            dstart_reg <= 1'b0;
            vdone_reg  <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            last_reg   <= last_next;
            avg_reg    <= avg_next;
            dstart_reg <= dstart_next;
            vdone_reg  <= vdone;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        pos_reg <= pos_next;
    end

    // done flag follows the average update, so pos and vel are settled
    assign sts.pos_done = pdone;
    assign sts.vel_done = vdone_reg;
    assign pos = pos_reg;
    assign vel = avg_reg;

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_start_idle, clk, rst_n, ctl.start, st_reg == ST_IDLE)
    `ASSERT_NEXT(a_done_to_idle, clk, rst_n, vdone, st_reg == ST_IDLE)
    `ASSERT_IMPL(a_last_stable, clk, rst_n, st_reg == ST_IDLE && !ctl.start, 1'b1 && $stable(last_reg) || $rose(st_reg == ST_IDLE))
endmodule

### hw/rtl/tpvt_merge.sv
// Merge stage: waits for both lanes, then holds the result for the sink.
module tpvt_merge
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  tpvt_pkg::lane_sts_t                sts_x,
    input  tpvt_pkg::lane_sts_t                sts_y,
    input  logic signed [tpvt_pkg::POS_W-1:0]  pos_x,
    input  logic signed [tpvt_pkg::POS_W-1:0]  pos_y,
    input  logic signed [tpvt_pkg::VEL_W-1:0]  vel_x,
    input  logic signed [tpvt_pkg::VEL_W-1:0]  vel_y,
    output logic                               all_done,
    tpvt_out_if.source                         out
);
    import tpvt_pkg::*;

    logic fx_reg, fx_next;
    logic fy_reg, fy_next;
    logic valid_reg, valid_next;
    logic signed [POS_W-1:0] px_reg, py_reg;
    logic signed [VEL_W-1:0] vx_reg, vy_reg;
    logic both;

    assign both = (fx_reg || sts_x.vel_done) && (fy_reg || sts_y.vel_done);

    // join the lane completions
    always_comb
    begin
        fx_next    = fx_reg || sts_x.vel_done;
        fy_next    = fy_reg || sts_y.vel_done;
        valid_next = valid_reg && !out.ready;
        if (both)
        begin
            fx_next    = 1'b0;
            fy_next    = 1'b0;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg    <= 1'b0;
            fy_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            fx_reg    <= fx_next;
            fy_reg    <= fy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (both)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            vx_reg <= vel_x;
            vy_reg <= vel_y;
        end
    end

    assign all_done  = both;
    assign out.valid = valid_reg;
    assign out.pos_x = px_reg;
    assign out.pos_y = py_reg;
    assign out.vel_x = vx_reg;
    assign out.vel_y = vy_reg;

    `include "assert_macros.svh"
    `ASSERT_NEXT(a_both_valid, clk, rst_n, both, valid_reg)
    `ASSERT_IMPL(a_no_overrun, clk, rst_n, both, !valid_reg || out.ready)
    `ASSERT_IMPL(a_vx_pos, clk, rst_n, sts_x.vel_done, !fx_reg)
endmodule

### hw/rtl/touch_position_velocity_tracker_unit.sv
// Touch position and velocity tracker.
// Channels: "in" takes one request per sample period (touch flag, raw X/Y,
// period in us); "out" returns one result per request (centred positions
// and running-average velocities); "cfg" writes the calibration registers
// and the averaging divisor by index.
// Two axis lanes run side by side; each pushes up to three signed divides
// (position, velocity, average) through its own 48-bit restoring divider,
// one quotient bit per cycle.
// For a touched sample with a nonzero calibration span each lane runs the
// position, velocity and average divides in turn; otherwise the position
// divide is skipped. A new request is taken only after the previous result
// has been taken, so requests do not overlap.
// Reset loads the register defaults and clears the held positions and
// averages; no result is pending after reset.
// When the receiver stalls, the result waits in the output register and
// no new request is taken until it has gone.
// Config writes are taken at any time and belong only while idle.
module touch_position_velocity_tracker_unit
(
    input  logic       clk,
    input  logic       rst_n,
    tpvt_in_if.sink    in,
    tpvt_out_if.source out,
    tpvt_cfg_if.sink   cfg
);
    import tpvt_pkg::*;

    axis_cfg_t         xcfg_reg, ycfg_reg;
    logic [SPAN_W-1:0] span_reg;
    logic              busy_reg, busy_next;
    logic              start;
    lane_ctl_t         ctl;
    lane_sts_t         sts_x, sts_y;
    logic signed [POS_W-1:0] pos_x, pos_y;
    logic signed [VEL_W-1:0] vel_x, vel_y;
    logic              all_done;
    logic [RAW_W-1:0]  rx_reg, ry_reg;
    logic [PER_W-1:0]  per_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xcfg_reg <= '{raw_max: 12'd3900, raw_min: 12'd130, len: 16'd45192};
            ycfg_reg <= '{raw_max: 12'd3900, raw_min: 12'd252, len: 16'd34658};
            span_reg <= 9'd8;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_X_MAX: xcfg_reg.raw_max <= cfg.data[RAW_W-1:0];
                REG_X_MIN: xcfg_reg.raw_min <= cfg.data[RAW_W-1:0];
                REG_X_LEN: xcfg_reg.len     <= cfg.data;
                REG_Y_MAX: ycfg_reg.raw_max <= cfg.data[RAW_W-1:0];
                REG_Y_MIN: ycfg_reg.raw_min <= cfg.data[RAW_W-1:0];
                REG_Y_LEN: ycfg_reg.len     <= cfg.data;
                REG_N:     span_reg         <= cfg.data[SPAN_W-1:0];
                default: ;
            endcase
        end
    end
    assign cfg.ready = 1'b1;

    // accept one request when lanes are idle and the output slot is free
    assign in.ready = !busy_reg && !out.valid;
    assign start    = in.valid && in.ready;
    assign ctl.start   = start;
    assign ctl.touched = in.is_touched;

    always_comb
    begin
        busy_next = busy_reg;
        if (start)
            busy_next = 1'b1;
        else if (all_done)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rx_reg  <= in.raw_x;
            ry_reg  <= in.raw_y;
            per_reg <= in.period_us;
        end
    end

    tpvt_lane u_lane_x
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .cfg    (xcfg_reg),
        .raw    (start ? in.raw_x : rx_reg),
        .period (per_reg),
        .span   (span_reg),
        .sts    (sts_x),
        .pos    (pos_x),
        .vel    (vel_x)
    );

    tpvt_lane u_lane_y
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .cfg    (ycfg_reg),
        .raw    (start ? in.raw_y : ry_reg),
        .period (per_reg),
        .span   (span_reg),
        .sts    (sts_y),
        .pos    (pos_y),
        .vel    (vel_y)
    );

    tpvt_merge u_merge
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .sts_x    (sts_x),
        .sts_y    (sts_y),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .vel_x    (vel_x),
        .vel_y    (vel_y),
        .all_done (all_done),
        .out      (out)
    );

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_start_not_busy, clk, rst_n, start, !busy_reg)
    `ASSERT_IMPL(a_done_only_busy, clk, rst_n, all_done, busy_reg)
    `ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy_reg)
endmodule

### tb/touch_position_velocity_tracker_unit_tb.sv
module touch_position_velocity_tracker_unit_tb;
    import tpvt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        touched;
        logic [11:0] raw_x;
        logic [11:0] raw_y;
        logic [15:0] period;
    } sample_t;

    typedef struct {
        logic signed [16:0] pos_x;
        logic signed [16:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } track_t;

    logic clk;
    logic rst_n;
    logic failed;

    tpvt_in_if  in_ch ();
    tpvt_out_if out_ch ();
    tpvt_cfg_if cfg_ch ();

    touch_position_velocity_tracker_unit DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch),
        .cfg   (cfg_ch)
    );

    // tracker model state
    logic [11:0] m_xmax, m_xmin, m_ymax, m_ymin;
    logic [15:0] m_xlen, m_ylen;
    logic [8:0]  m_span;
    longint      m_last_x, m_last_y, m_avg_x, m_avg_y;

    sample_t pending_samples[$];
    track_t  expected_tracks[$];

    // handshakes seen at the last rising edge
    logic    in_fire;
    logic    out_fire;

    always #5 clk = ~clk;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint map_axis(logic [11:0] raw, logic [11:0] mx, logic [11:0] mn,
                                        logic [15:0] len);
        longint den;
        longint num;
        den = 2 * (longint'(mx) - longint'(mn));
        if (den == 0)
            return 0;
        num = (2 * longint'(raw) - longint'(mx) - longint'(mn)) * longint'(len);
        return clamp(num / den, -65536, 65535);
    endfunction

    function automatic longint next_avg(longint pos, longint prev, longint avg, longint per,
                                        longint n);
        longint v;
        v = (pos - prev) * 1000000 / per;
        return clamp(avg + (v - avg) / n, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic track_t predict_track(sample_t s);
        track_t t;
        longint per;
        longint n;
        longint px;
        longint py;
        per = (s.period == 0) ? 1 : longint'(s.period);
        n   = (m_span == 0) ? 1 : longint'(m_span);
        px  = m_last_x;
        py  = m_last_y;
        if (s.touched)
        begin
            px = map_axis(s.raw_x, m_xmax, m_xmin, m_xlen);
            py = map_axis(s.raw_y, m_ymax, m_ymin, m_ylen);
        end
        m_avg_x  = next_avg(px, m_last_x, m_avg_x, per, n);
        m_avg_y  = next_avg(py, m_last_y, m_avg_y, per, n);
        m_last_x = px;
        m_last_y = py;
        t.pos_x = px[16:0];
        t.pos_y = py[16:0];
        t.vel_x = m_avg_x[31:0];
        t.vel_y = m_avg_y[31:0];
        return t;
    endfunction

    // request driver
    int in_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_gap = $urandom_range(0, 10);
        end
        else if (in_fire)
        begin
            void'(pending_samples.pop_front());
            in_gap = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0)
                in_gap = 0;
            if (pending_samples.size() > 0 && in_gap == 0)
            begin
                in_ch.is_touched <= pending_samples[0].touched;
                in_ch.raw_x      <= pending_samples[0].raw_x;
                in_ch.raw_y      <= pending_samples[0].raw_y;
                in_ch.period_us  <= pending_samples[0].period;
            end
            else
                in_ch.valid <= 1'b0;
        end
        else if (!in_ch.valid && pending_samples.size() > 0)
        begin
            if (in_gap > 0)
                in_gap--;
            else
            begin
                in_ch.valid      <= 1'b1;
                in_ch.is_touched <= pending_samples[0].touched;
                in_ch.raw_x      <= pending_samples[0].raw_x;
                in_ch.raw_y      <= pending_samples[0].raw_y;
                in_ch.period_us  <= pending_samples[0].period;
            end
        end
    end

    // accepted requests feed the model
    always @(posedge clk)
    begin
        in_fire = rst_n && in_ch.valid && in_ch.ready;
        if (in_fire)
            expected_tracks.push_back(predict_track(pending_samples[0]));
    end

    // result receiver stalls
    int out_stall;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_stall = 0;
        end
        else if (out_stall > 0)
        begin
            out_stall--;
            out_ch.ready <= 1'b0;
        end
        else if (out_fire)
        begin
            out_stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            out_ch.ready <= (out_stall == 0);
        end
        else
            out_ch.ready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        track_t exp_t;
        out_fire = rst_n && out_ch.valid && out_ch.ready;
        if (out_fire)
        begin
            if (expected_tracks.size() == 0)
            begin
                $error("unexpected result");
                failed = 1'b1;
            end
            else
            begin
                exp_t = expected_tracks.pop_front();
                if (out_ch.pos_x !== exp_t.pos_x)
                begin
                    $error("pos_x expected %0d actual %0d", exp_t.pos_x, out_ch.pos_x);
                    failed = 1'b1;
                end
                if (out_ch.pos_y !== exp_t.pos_y)
                begin
                    $error("pos_y expected %0d actual %0d", exp_t.pos_y, out_ch.pos_y);
                    failed = 1'b1;
                end
                if (out_ch.vel_x !== exp_t.vel_x)
                begin
                    $error("vel_x expected %0d actual %0d", exp_t.vel_x, out_ch.vel_x);
                    failed = 1'b1;
                end
                if (out_ch.vel_y !== exp_t.vel_y)
                begin
                    $error("vel_y expected %0d actual %0d", exp_t.vel_y, out_ch.vel_y);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_X_MAX: m_xmax = value[11:0];
            REG_X_MIN: m_xmin = value[11:0];
            REG_X_LEN: m_xlen = value;
            REG_Y_MAX: m_ymax = value[11:0];
            REG_Y_MIN: m_ymin = value[11:0];
            REG_Y_LEN: m_ylen = value;
            REG_N:     m_span = value[8:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic add_sample(logic t, logic [11:0] x, logic [11:0] y, logic [15:0] p);
        sample_t s;
        s.touched = t;
        s.raw_x   = x;
        s.raw_y   = y;
        s.period  = p;
        pending_samples.push_back(s);
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || expected_tracks.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic random_burst(int count);
        repeat (count)
        begin
            add_sample($urandom_range(0, 4) != 0, 12'($urandom_range(0, 4095)),
                       12'($urandom_range(0, 4095)),
                       ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(0, 2000)));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        failed = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.is_touched = 1'b0;
        in_ch.raw_x = '0;
        in_ch.raw_y = '0;
        in_ch.period_us = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_X_MAX;
        cfg_ch.data = '0;
        m_xmax = 12'd3900; m_xmin = 12'd130; m_xlen = 16'd45192;
        m_ymax = 12'd3900; m_ymin = 12'd252; m_ylen = 16'd34658;
        m_span = 9'd8;
        m_last_x = 0; m_last_y = 0; m_avg_x = 0; m_avg_y = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, zero period, untouched hold and decay
        add_sample(1'b1, 12'd0, 12'd0, 16'd1);
        add_sample(1'b1, 12'hFFF, 12'hFFF, 16'd0);
        add_sample(1'b0, 12'hFFF, 12'h000, 16'hFFFF);
        add_sample(1'b0, 12'h000, 12'hFFF, 16'd0);
        add_sample(1'b1, 12'd2015, 12'd2076, 16'd1000);
        add_sample(1'b1, 12'hAAA, 12'h555, 16'hAAAA);
        add_sample(1'b1, 12'h555, 12'hAAA, 16'h5555);
        drain();

        // equal min and max on X, reversed span on Y, max lengths, N of one
        write_reg(REG_X_MAX, 16'd2000);
        write_reg(REG_X_MIN, 16'd2000);
        write_reg(REG_X_LEN, 16'hFFFF);
        write_reg(REG_Y_MAX, 16'd0);
        write_reg(REG_Y_MIN, 16'd4095);
        write_reg(REG_Y_LEN, 16'hFFFF);
        write_reg(REG_N, 16'd1);
        add_sample(1'b1, 12'd0, 12'd0, 16'd1);
        add_sample(1'b1, 12'hFFF, 12'hFFF, 16'd1);
        add_sample(1'b0, 12'd0, 12'd0, 16'd1);
        drain();

        // tiny span saturates X positions; zero N and N of 256
        write_reg(REG_X_MAX, 16'd2001);
        write_reg(REG_X_MIN, 16'd2000);
        write_reg(REG_Y_MAX, 16'd4095);
        write_reg(REG_Y_MIN, 16'd0);
        write_reg(REG_Y_LEN, 16'd1);
        write_reg(REG_N, 16'd0);
        add_sample(1'b1, 12'hFFF, 12'd0, 16'd1);
        add_sample(1'b1, 12'd0, 12'hFFF, 16'd1);
        add_sample(1'b1, 12'hFFF, 12'd2048, 16'd0);
        random_burst(150);
        drain();
        write_reg(REG_N, 16'd256);
        write_reg(REG_X_LEN, 16'd1);
        random_burst(150);
        drain();

        // random calibrations
        repeat (4)
        begin
            write_reg(REG_X_MAX, 16'($urandom_range(0, 4095)));
            write_reg(REG_X_MIN, 16'($urandom_range(0, 4095)));
            write_reg(REG_X_LEN, 16'($urandom_range(1, 65535)));
            write_reg(REG_Y_MAX, 16'($urandom_range(0, 4095)));
            write_reg(REG_Y_MIN, 16'($urandom_range(0, 4095)));
            write_reg(REG_Y_LEN, 16'($urandom_range(1, 65535)));
            write_reg(REG_N, 16'($urandom_range(1, 256)));
            random_burst(120);
            drain();
        end

        if (!failed)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/tpvt_pkg.sv
hw/rtl/tpvt_if.sv
hw/rtl/tpvt_div.sv
hw/rtl/tpvt_lane.sv
hw/rtl/tpvt_merge.sv
hw/rtl/touch_position_velocity_tracker_unit.sv
tb/touch_position_velocity_tracker_unit_tb.sv
